/* hw/rtl/dcog_pkg.sv */
`default_nettype none

package dcog_pkg;

    localparam int DAC_BITS  = 12;
    localparam int OUT_W     = 16;
    localparam int SAMPLE_W  = 32;
    localparam int CFG_W     = 32;
    localparam int MAG_W     = 32;
    localparam int PROD_W    = MAG_W + DAC_BITS;
    localparam int CNT_W     = $clog2(PROD_W);
    localparam int REG_IDX_W = 3;

    localparam logic [DAC_BITS-1:0] DAC_FULL = {DAC_BITS{1'b1}};
    localparam logic [DAC_BITS-1:0] DAC_HALF = {1'b1, {(DAC_BITS-1){1'b0}}};

    localparam logic [2:0] MODE_DATA   = 3'd0;
    localparam logic [2:0] MODE_RAMP   = 3'd1;
    localparam logic [2:0] MODE_FULL   = 3'd2;
    localparam logic [2:0] MODE_ZERO   = 3'd3;
    localparam logic [2:0] MODE_QUANTA = 3'd4;

    localparam logic [2:0] FMT_U8   = 3'd0;
    localparam logic [2:0] FMT_U16  = 3'd1;
    localparam logic [2:0] FMT_U32  = 3'd2;
    localparam logic [2:0] FMT_S8   = 3'd3;
    localparam logic [2:0] FMT_S16  = 3'd4;
    localparam logic [2:0] FMT_S32  = 3'd5;
    localparam logic [2:0] FMT_NONE = 3'd6;

    localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CLAMP  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAX    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MIN    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STEP   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_QUANTA = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_FORMAT = 3'd7;

    typedef struct packed {
        logic              output_enable;
        logic [2:0]        output_mode;
        logic              clamp_enable;
        logic [MAG_W-1:0]  scale_max;
        logic [MAG_W-1:0]  scale_min;
        logic [OUT_W-1:0]  ramp_step;
        logic [OUT_W-1:0]  quanta_code;
        logic [2:0]        sample_format;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } scl_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/dcog_cfg_regs.sv */
`default_nettype none

module dcog_cfg_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dcog_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [dcog_pkg::CFG_W-1:0]      cfg_wr_data,
    output dcog_pkg::cfg_t                       cfg,
    output logic                                 mode_wr
);

    dcog_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.output_enable <= 1'b0;
            cfg_reg.output_mode   <= dcog_pkg::MODE_DATA;
            cfg_reg.clamp_enable  <= 1'b1;
            cfg_reg.scale_max     <= {{(dcog_pkg::MAG_W-1){1'b0}}, 1'b1};
            cfg_reg.scale_min     <= {{(dcog_pkg::MAG_W-1){1'b0}}, 1'b1};
            cfg_reg.ramp_step     <= '0;
            cfg_reg.quanta_code   <= '0;
            cfg_reg.sample_format <= dcog_pkg::FMT_NONE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dcog_pkg::REG_ENABLE: cfg_reg.output_enable <= cfg_wr_data[0];
                dcog_pkg::REG_MODE:   cfg_reg.output_mode   <= cfg_wr_data[2:0];
                dcog_pkg::REG_CLAMP:  cfg_reg.clamp_enable  <= cfg_wr_data[0];
                dcog_pkg::REG_MAX:    cfg_reg.scale_max     <= cfg_wr_data[dcog_pkg::MAG_W-1:0];
                dcog_pkg::REG_MIN:    cfg_reg.scale_min     <= cfg_wr_data[dcog_pkg::MAG_W-1:0];
                dcog_pkg::REG_STEP:   cfg_reg.ramp_step     <= cfg_wr_data[dcog_pkg::OUT_W-1:0];
                dcog_pkg::REG_QUANTA: cfg_reg.quanta_code   <= cfg_wr_data[dcog_pkg::OUT_W-1:0];
                dcog_pkg::REG_FORMAT: cfg_reg.sample_format <= cfg_wr_data[2:0];
                default: ;
            endcase
        end
    end

    assign cfg     = cfg_reg;
    assign mode_wr = cfg_wr_en && (cfg_index == dcog_pkg::REG_MODE);

endmodule

`default_nettype wire

/* hw/rtl/dcog_scaler.sv */
`default_nettype none

module dcog_scaler (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [dcog_pkg::SAMPLE_W-1:0]    sample,
    input  wire dcog_pkg::cfg_t                   cfg,
    output dcog_pkg::scl_stat_t                   stat,
    output logic [dcog_pkg::DAC_BITS-1:0]         code
);

    localparam int MW = dcog_pkg::MAG_W;
    localparam int PW = dcog_pkg::PROD_W;
    localparam int DB = dcog_pkg::DAC_BITS;

    typedef enum logic [3:0] {
        SC_IDLE = 4'b0001,
        SC_PREP = 4'b0010,
        SC_MUL  = 4'b0100,
        SC_DIV  = 4'b1000
    } sc_state_t;

    sc_state_t                     state_reg;
    logic                          done_reg;
    logic [dcog_pkg::SAMPLE_W-1:0] sample_reg;
    logic [MW-1:0]                 mag_reg;
    logic [MW-1:0]                 div_reg;
    logic                          neg_reg;
    logic [MW-1:0]                 rem_reg;
    logic [MW-1:0]                 rem_next;
    logic [PW-1:0]                 quo_reg;
    logic [dcog_pkg::CNT_W-1:0]    cnt_reg;

    logic [dcog_pkg::SAMPLE_W-1:0] ext;
    logic [MW:0]                   num_w;
    logic [MW:0]                   num_neg;
    logic [MW-1:0]                 num_mag;
    logic [MW:0]                   diff_w;
    logic [MW:0]                   diff_neg;
    logic [MW-1:0]                 diff_mag;
    logic [MW-1:0]                 div_val;
    logic [PW-1:0]                 prod;
    logic [MW:0]                   trial;
    logic [MW+1:0]                 sub;
    logic                          take;
    logic [DB-1:0]                 q_lo;
    logic [DB-1:0]                 clamp_code;
    logic [DB-1:0]                 wrap_code;

    always_comb begin
        case (cfg.sample_format)
            dcog_pkg::FMT_U8:  ext = {{(dcog_pkg::SAMPLE_W-8){1'b0}}, sample_reg[7:0]};
            dcog_pkg::FMT_U16: ext = {{(dcog_pkg::SAMPLE_W-16){1'b0}}, sample_reg[15:0]};
            dcog_pkg::FMT_S8:  ext = {{(dcog_pkg::SAMPLE_W-8){sample_reg[7]}}, sample_reg[7:0]};
            dcog_pkg::FMT_S16: ext = {{(dcog_pkg::SAMPLE_W-16){sample_reg[15]}},
                                      sample_reg[15:0]};
            default:           ext = sample_reg;
        endcase
    end

    assign num_w    = {ext[MW-1], ext} - {cfg.scale_min[MW-1], cfg.scale_min};
    assign num_neg  = ~num_w + {{MW{1'b0}}, 1'b1};
    assign num_mag  = num_w[MW] ? num_neg[MW-1:0] : num_w[MW-1:0];

    assign diff_w   = {cfg.scale_max[MW-1], cfg.scale_max}
                    - {cfg.scale_min[MW-1], cfg.scale_min};
    assign diff_neg = ~diff_w + {{MW{1'b0}}, 1'b1};
    assign diff_mag = diff_w[MW] ? diff_neg[MW-1:0] : diff_w[MW-1:0];
    assign div_val  = (diff_mag == '0) ? {{(MW-1){1'b0}}, 1'b1} : diff_mag;

    assign prod     = {mag_reg, {DB{1'b0}}} - {{DB{1'b0}}, mag_reg};

    assign trial    = {rem_reg, quo_reg[PW-1]};
    assign sub      = {1'b0, trial} - {2'b00, div_reg};
    assign take     = !sub[MW+1];
    assign rem_next = take ? sub[MW-1:0] : trial[MW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                SC_IDLE: begin
                    if (start) begin
                        sample_reg <= sample;
                        state_reg  <= SC_PREP;
                    end
                end
                SC_PREP: begin
                    mag_reg   <= num_mag;
                    div_reg   <= div_val;
                    neg_reg   <= num_w[MW];
                    state_reg <= SC_MUL;
                end
                SC_MUL: begin
                    quo_reg   <= prod;
                    rem_reg   <= '0;
                    cnt_reg   <= dcog_pkg::CNT_W'(PW - 1);
                    state_reg <= SC_DIV;
                end
                SC_DIV: begin
                    quo_reg <= {quo_reg[PW-2:0], take};
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        done_reg  <= 1'b1;
                        state_reg <= SC_IDLE;
                    end
                end
                default: state_reg <= SC_IDLE;
            endcase
        end
    end

    assign q_lo       = quo_reg[DB-1:0];
    assign clamp_code = neg_reg ? '0 :
                        ((quo_reg[PW-1:DB] == '0) ? q_lo : dcog_pkg::DAC_FULL);
    assign wrap_code  = neg_reg ? (~q_lo + {{(DB-1){1'b0}}, 1'b1}) : q_lo;

    assign code      = cfg.clamp_enable ? clamp_code : wrap_code;
    assign stat.busy = (state_reg != SC_IDLE);
    assign stat.done = done_reg;

endmodule

`default_nettype wire

/* hw/rtl/dac_channel_output_generator.sv */
// One DAC channel. Each beat on the s_ channel is a service tick carrying the
// current raw sample word; each beat on the m_ channel is one DAC code.
// A tick taken while output_enable is 0 is dropped and gives no code.
// Ramp, full scale, zero and quanta modes, and data mode with no sample format
// selected, place the code in a result register and then in the output register
// that drives m_valid. Data mode runs the scaler: it first extends the sample
// and forms |sample - min| and |max - min|, then multiplies by full scale, then
// a restoring divider retires one quotient bit per cycle over 44 bits; the
// scaler's code then passes through the same result and output registers.
// One tick is in flight at a time; s_ready rises again once the code has
// moved into the output register, so the next tick is taken while that code
// still waits for m_ready. When the receiver stalls, the code holds in the
// output register and a finished next code waits behind it.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wr_data);
// write only while no tick is in flight. Writing output_mode clears the ramp.
// aresetn is synchronous and active low; it restores the register defaults,
// clears the ramp and empties the output register.
`default_nettype none

module dac_channel_output_generator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [dcog_pkg::SAMPLE_W-1:0]   s_sample_bits,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [dcog_pkg::OUT_W-1:0]           m_dac_code,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dcog_pkg::REG_IDX_W-1:0]  cfg_index,
    input  wire logic [dcog_pkg::CFG_W-1:0]      cfg_wr_data
);

    localparam int DB = dcog_pkg::DAC_BITS;
    localparam int OW = dcog_pkg::OUT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_HOLD = 3'b100
    } top_state_t;

    dcog_pkg::cfg_t      cfg;
    dcog_pkg::scl_stat_t scl_stat;
    logic                mode_wr;
    logic [DB-1:0]       scl_code;

    top_state_t          state_reg;
    logic [DB-1:0]       ramp_reg;
    logic [DB-1:0]       ramp_sum;
    logic [OW-1:0]       res_reg;
    logic [OW-1:0]       m_code_reg;
    logic                m_valid_reg;
    logic [OW-1:0]       direct_code;
    logic                accept;
    logic                needs_div;
    logic                scl_start;
    logic                out_load;

    dcog_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg),
        .mode_wr     (mode_wr)
    );

    dcog_scaler u_scaler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scl_start),
        .sample  (s_sample_bits),
        .cfg     (cfg),
        .stat    (scl_stat),
        .code    (scl_code)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign needs_div = (cfg.output_mode == dcog_pkg::MODE_DATA) &&
                       (cfg.sample_format != dcog_pkg::FMT_NONE);
    assign scl_start = accept && cfg.output_enable && needs_div;
    assign ramp_sum  = ramp_reg + cfg.ramp_step[DB-1:0];
    assign out_load  = (state_reg == ST_HOLD) && (!m_valid_reg || m_ready);

    always_comb begin
        case (cfg.output_mode)
            dcog_pkg::MODE_DATA:   direct_code = {{(OW-DB){1'b0}}, dcog_pkg::DAC_HALF};
            dcog_pkg::MODE_RAMP:   direct_code = {{(OW-DB){1'b0}}, ramp_sum};
            dcog_pkg::MODE_FULL:   direct_code = {{(OW-DB){1'b0}}, dcog_pkg::DAC_FULL};
            dcog_pkg::MODE_QUANTA: direct_code = cfg.quanta_code;
            default:               direct_code = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ramp_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (mode_wr) begin
                ramp_reg <= '0;
            end else if (accept && cfg.output_enable &&
                         (cfg.output_mode == dcog_pkg::MODE_RAMP)) begin
                ramp_reg <= ramp_sum;
            end

            if (out_load) begin
                m_code_reg  <= res_reg;
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept && cfg.output_enable) begin
                        if (needs_div) begin
                            state_reg <= ST_CALC;
                        end else begin
                            res_reg   <= direct_code;
                            state_reg <= ST_HOLD;
                        end
                    end
                end
                ST_CALC: begin
                    if (scl_stat.done) begin
                        res_reg   <= {{(OW-DB){1'b0}}, scl_code};
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_dac_code = m_code_reg;

    ap_busy_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        scl_stat.busy |-> state_reg == ST_CALC)
        else $error("scaler busy outside calc state");

    ap_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        scl_stat.done |-> state_reg == ST_CALC)
        else $error("scaler done outside calc state");

    ap_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        scl_start |=> scl_stat.busy)
        else $error("scaler did not start");

    ap_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (cfg.output_mode != dcog_pkg::MODE_QUANTA))
        |-> (m_code_reg[OW-1:DB] == '0))
        else $error("code outside DAC range");

endmodule

`default_nettype wire

/* bench/tb.sv */
`default_nettype none

module tb;

    localparam int OW = dcog_pkg::OUT_W;
    localparam int DB = dcog_pkg::DAC_BITS;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam logic [2:0] FMT_SPARE     = 3'd7;
    localparam int ITEM_TARGET = 450;
    localparam int SETTLE      = 60;
    localparam int DRAIN_BOUND = 20000;
    localparam int unsigned CYCLE_LIMIT = 600000;

    class dac_code_tracker;
        dcog_pkg::cfg_t   regs;
        logic [DB-1:0]    ramp;
        logic [OW-1:0]    awaited_codes[$];
        int               errors;
        int               ticks_noted;

        function new();
            regs = '0;
            regs.clamp_enable  = 1'b1;
            regs.scale_max     = 32'd1;
            regs.scale_min     = 32'd1;
            regs.output_mode   = dcog_pkg::MODE_DATA;
            regs.sample_format = dcog_pkg::FMT_NONE;
            ramp = '0;
            errors = 0;
            ticks_noted = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        function void write_reg(logic [dcog_pkg::REG_IDX_W-1:0] idx,
                                logic [dcog_pkg::CFG_W-1:0] data);
            case (idx)
                dcog_pkg::REG_ENABLE: regs.output_enable = data[0];
                dcog_pkg::REG_MODE: begin
                    regs.output_mode = data[2:0];
                    ramp = '0;
                end
                dcog_pkg::REG_CLAMP:  regs.clamp_enable  = data[0];
                dcog_pkg::REG_MAX:    regs.scale_max     = data[dcog_pkg::MAG_W-1:0];
                dcog_pkg::REG_MIN:    regs.scale_min     = data[dcog_pkg::MAG_W-1:0];
                dcog_pkg::REG_STEP:   regs.ramp_step     = data[OW-1:0];
                dcog_pkg::REG_QUANTA: regs.quanta_code   = data[OW-1:0];
                dcog_pkg::REG_FORMAT: regs.sample_format = data[2:0];
                default: ;
            endcase
        endfunction

        function logic [OW-1:0] scaled_code(logic [dcog_pkg::SAMPLE_W-1:0] bits);
            longint full_scale;
            longint sample;
            longint lo;
            longint hi;
            longint span;
            longint q;
            full_scale = (64'sd1 <<< DB) - 1;
            case (regs.sample_format)
                dcog_pkg::FMT_U8:  sample = longint'(bits[7:0]);
                dcog_pkg::FMT_U16: sample = longint'(bits[15:0]);
                dcog_pkg::FMT_S8:  sample = longint'($signed(bits[7:0]));
                dcog_pkg::FMT_S16: sample = longint'($signed(bits[15:0]));
                default:           sample = longint'($signed(bits[31:0]));
            endcase
            lo = longint'($signed(regs.scale_min));
            hi = longint'($signed(regs.scale_max));
            if (hi == lo)
                span = 1;
            else
                span = (hi > lo) ? hi - lo : lo - hi;
            q = (sample - lo) * full_scale / span;
            if (regs.clamp_enable) begin
                if (q > full_scale)
                    q = full_scale;
                else if (q < 0)
                    q = 0;
            end else begin
                q = q % (full_scale + 1);
                if (q < 0)
                    q = q + full_scale + 1;
            end
            return q[OW-1:0];
        endfunction

        function void note_tick(logic [dcog_pkg::SAMPLE_W-1:0] bits);
            logic [OW-1:0] code;
            ticks_noted++;
            if (!regs.output_enable)
                return;
            case (regs.output_mode)
                dcog_pkg::MODE_DATA:
                    code = (regs.sample_format == dcog_pkg::FMT_NONE) ?
                           OW'(dcog_pkg::DAC_HALF) : scaled_code(bits);
                dcog_pkg::MODE_RAMP: begin
                    ramp = ramp + regs.ramp_step[DB-1:0];
                    code = OW'(ramp);
                end
                dcog_pkg::MODE_FULL:   code = OW'(dcog_pkg::DAC_FULL);
                dcog_pkg::MODE_QUANTA: code = regs.quanta_code;
                default:               code = '0;
            endcase
            awaited_codes.push_back(code);
        endfunction

        task check_code(logic [OW-1:0] code);
            logic [OW-1:0] want;
            if (awaited_codes.size() == 0) begin
                report($sformatf("dac_code 0x%04h with no tick waiting at %0t", code, $time));
                return;
            end
            want = awaited_codes.pop_front();
            if (code !== want)
                report($sformatf("dac_code 0x%04h, want 0x%04h at %0t", code, want, $time));
        endtask
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [dcog_pkg::SAMPLE_W-1:0]  s_sample_bits = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [OW-1:0]                  m_dac_code;
    logic                           cfg_wr_en = 1'b0;
    logic [dcog_pkg::REG_IDX_W-1:0] cfg_index = '0;
    logic [dcog_pkg::CFG_W-1:0]     cfg_wr_data = '0;

    bit                   calm = 1'b0;
    int unsigned          cycles = 0;
    dac_code_tracker      tracker;

    logic [31:0] corners [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0080, 32'h0000_007F,
                                 32'h0000_8000, 32'h0000_7FFF, 32'h8000_0000, 32'h7FFF_FFFF};

    dac_channel_output_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_bits (s_sample_bits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dac_code    (m_dac_code),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 23);
    end

    always @(posedge aclk) begin
        cycles++;
        if (aresetn && m_valid && m_ready)
            tracker.check_code(m_dac_code);
        if (cycles > CYCLE_LIMIT) begin
            $display("dac_channel_output_generator verification failed");
            $finish;
        end
    end

    function automatic longint unsigned wide_rand();
        return {$urandom, $urandom};
    endfunction

    task automatic send_tick(input logic [dcog_pkg::SAMPLE_W-1:0] bits);
        int gap;
        if (!calm && $urandom_range(99) < 23) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_sample_bits <= bits;
        do @(posedge aclk); while (!s_ready);
        tracker.note_tick(bits);
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (tracker.awaited_codes.size() != 0 && waited < DRAIN_BOUND) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE) @(posedge aclk);
        if (tracker.awaited_codes.size() != 0) begin
            tracker.report($sformatf("%0d codes never arrived", tracker.awaited_codes.size()));
            tracker.awaited_codes.delete();
        end
    endtask

    task automatic cfg_write(input logic [dcog_pkg::REG_IDX_W-1:0] idx,
                             input logic [dcog_pkg::CFG_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        tracker.write_reg(idx, data);
    endtask

    task automatic cfg_close();
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(input int phase_no);
        int r;
        int n;
        logic [2:0] fmt;
        logic [2:0] mode;
        logic [31:0] keep_mask;
        logic [31:0] word;
        longint dom_lo;
        longint dom_hi;
        longint a;
        longint b;
        longint lo;
        longint hi;
        longint val;
        drain();
        calm = (phase_no >= 8 && phase_no < 12);
        cfg_write(dcog_pkg::REG_ENABLE, ($urandom & ~32'h1) | 32'($urandom_range(99) < 88));
        if ($urandom_range(99) < 55) begin
            r = $urandom_range(99);
            if (r < 50)      mode = dcog_pkg::MODE_DATA;
            else if (r < 70) mode = dcog_pkg::MODE_RAMP;
            else if (r < 78) mode = dcog_pkg::MODE_FULL;
            else if (r < 86) mode = dcog_pkg::MODE_ZERO;
            else if (r < 95) mode = dcog_pkg::MODE_QUANTA;
            else             mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
            cfg_write(dcog_pkg::REG_MODE, ($urandom & ~32'h7) | 32'(mode));
        end
        cfg_write(dcog_pkg::REG_CLAMP, ($urandom & ~32'h1) | 32'($urandom_range(1)));
        if ($urandom_range(99) < 80)
            cfg_write(dcog_pkg::REG_FORMAT, ($urandom & ~32'h7) | 32'($urandom_range(7)));
        fmt = tracker.regs.sample_format;
        case (fmt)
            dcog_pkg::FMT_U8: begin
                dom_lo = 0;      dom_hi = 255;   keep_mask = 32'h0000_00FF;
            end
            dcog_pkg::FMT_U16: begin
                dom_lo = 0;      dom_hi = 65535; keep_mask = 32'h0000_FFFF;
            end
            dcog_pkg::FMT_S8: begin
                dom_lo = -128;   dom_hi = 127;   keep_mask = 32'h0000_00FF;
            end
            dcog_pkg::FMT_S16: begin
                dom_lo = -32768; dom_hi = 32767; keep_mask = 32'h0000_FFFF;
            end
            default: begin
                dom_lo = -64'sd2147483648;
                dom_hi = 64'sd2147483647;
                keep_mask = 32'hFFFF_FFFF;
            end
        endcase
        r = $urandom_range(99);
        a = dom_lo + longint'(wide_rand() % longint'(dom_hi - dom_lo + 1));
        b = dom_lo + longint'(wide_rand() % longint'(dom_hi - dom_lo + 1));
        if (r < 15) begin
            b = a;
        end else if (r < 30) begin
            a = longint'($signed($urandom));
            b = longint'($signed($urandom));
        end else if (r < 40) begin
            a = $urandom_range(1) ? 64'sd2147483647 : -64'sd2147483648;
            b = (a > 0) ? -64'sd2147483648 : 64'sd2147483647;
        end
        cfg_write(dcog_pkg::REG_MAX, a[31:0]);
        cfg_write(dcog_pkg::REG_MIN, b[31:0]);
        if ($urandom_range(99) < 60)
            cfg_write(dcog_pkg::REG_STEP, {$urandom} & 32'hFFFF);
        if ($urandom_range(99) < 60)
            cfg_write(dcog_pkg::REG_QUANTA, {$urandom} & 32'hFFFF);
        cfg_close();
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        n = $urandom_range(10, 30);
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 45) begin
                val = lo + longint'(wide_rand() % longint'(hi - lo + 1));
                word = ($urandom & ~keep_mask) | (val[31:0] & keep_mask);
            end else if (r < 85) begin
                word = $urandom;
            end else begin
                word = corners[$urandom_range(7)];
            end
            send_tick(word);
        end
    endtask

    initial begin
        int phase_no;
        tracker = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        send_tick(32'hFFFF_FFFF);
        send_tick(32'h0000_0000);
        drain();
        cfg_write(dcog_pkg::REG_ENABLE, 32'h1);
        cfg_close();
        send_tick(32'h1234_5678);

        drain();
        cfg_write(dcog_pkg::REG_FORMAT, 32'(dcog_pkg::FMT_U8));
        cfg_write(dcog_pkg::REG_MAX, 32'd255);
        cfg_write(dcog_pkg::REG_MIN, 32'd0);
        cfg_close();
        send_tick(32'h0000_0000);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'hABCD_EF80);

        drain();
        cfg_write(dcog_pkg::REG_FORMAT, 32'(dcog_pkg::FMT_S32));
        cfg_write(dcog_pkg::REG_MAX, 32'h7FFF_FFFF);
        cfg_write(dcog_pkg::REG_MIN, 32'h8000_0000);
        cfg_close();
        send_tick(32'h8000_0000);
        send_tick(32'h7FFF_FFFF);
        send_tick(32'h0000_0000);

        drain();
        cfg_write(dcog_pkg::REG_FORMAT, 32'(dcog_pkg::FMT_S8));
        cfg_write(dcog_pkg::REG_MAX, 32'd5);
        cfg_write(dcog_pkg::REG_MIN, 32'd5);
        cfg_close();
        send_tick(32'h0000_0006);
        send_tick(32'h0000_0004);
        drain();
        cfg_write(dcog_pkg::REG_CLAMP, 32'h0);
        cfg_close();
        send_tick(32'h0000_0007);
        send_tick(32'h0000_0003);
        send_tick(32'hFFFF_FF80);

        drain();
        cfg_write(dcog_pkg::REG_FORMAT, 32'(dcog_pkg::FMT_S16));
        cfg_write(dcog_pkg::REG_MAX, 32'hFFFF_8000);
        cfg_write(dcog_pkg::REG_MIN, 32'd32767);
        cfg_close();
        send_tick(32'h0000_8000);
        send_tick(32'hFFFF_7FFF);

        drain();
        cfg_write(dcog_pkg::REG_FORMAT, 32'(FMT_SPARE));
        cfg_write(dcog_pkg::REG_CLAMP, 32'h1);
        cfg_write(dcog_pkg::REG_MAX, 32'h7FFF_FFFF);
        cfg_write(dcog_pkg::REG_MIN, 32'hFFFF_FFFF);
        cfg_close();
        send_tick(32'h4000_0000);

        drain();
        cfg_write(dcog_pkg::REG_MODE, 32'(dcog_pkg::MODE_RAMP));
        cfg_write(dcog_pkg::REG_STEP, 32'h0000_FFFF);
        cfg_close();
        send_tick($urandom);
        send_tick($urandom);
        send_tick($urandom);

        drain();
        cfg_write(dcog_pkg::REG_MODE, 32'(dcog_pkg::MODE_FULL));
        cfg_close();
        send_tick($urandom);
        drain();
        cfg_write(dcog_pkg::REG_MODE, 32'(dcog_pkg::MODE_ZERO));
        cfg_close();
        send_tick($urandom);
        drain();
        cfg_write(dcog_pkg::REG_MODE, 32'(dcog_pkg::MODE_QUANTA));
        cfg_write(dcog_pkg::REG_QUANTA, 32'h0000_FFFF);
        cfg_close();
        send_tick($urandom);
        drain();
        cfg_write(dcog_pkg::REG_MODE, 32'(MODE_SPARE_HI));
        cfg_close();
        send_tick($urandom);

        phase_no = 0;
        while (tracker.ticks_noted < ITEM_TARGET) begin
            random_phase(phase_no);
            phase_no++;
        end
        calm = 1'b0;
        drain();

        if (tracker.errors == 0)
            $display("dac_channel_output_generator verification clean");
        else
            $display("dac_channel_output_generator verification failed");
        $finish;
    end
endmodule

`default_nettype wire
